### rtl/sxor_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sxor_pkg - shared types, constants and round functions
// Salsa20 state layout, configuration record and the structs that travel
// between the front, the back and the block generator.
// ============================================================================
package sxor_pkg;

    localparam int BLOCK_BITS = 512;
    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_A      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_B      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_C      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_D      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONCE      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_MODE = 3'd5;

    // sigma and tau diagonal constants
    localparam logic [31:0] SIG0 = 32'h61707865;
    localparam logic [31:0] SIG1 = 32'h3320646e;
    localparam logic [31:0] SIG2 = 32'h79622d32;
    localparam logic [31:0] SIG3 = 32'h6b206574;
    localparam logic [31:0] TAU0 = 32'h61707865;
    localparam logic [31:0] TAU1 = 32'h3120646e;
    localparam logic [31:0] TAU2 = 32'h79622d36;
    localparam logic [31:0] TAU3 = 32'h6b206574;

    typedef logic [15:0][31:0] t_state;

    typedef struct packed {
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        logic [63:0] key_d;
        logic [63:0] nonce;
        logic        short_mode;
    } t_cfg;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        need;
        logic [63:0] ctr;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic        start;
        logic        take;
        logic        flush;
        logic [63:0] ctr;
    } t_core_ctl;

    typedef struct packed {
        logic        busy;
        logic [63:0] tag;
        logic        valid;
        logic [63:0] ctr;
    } t_core_stat;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_state quarter(input t_state w_in, input int a, input int b,
                                       input int c, input int d);
        t_state w;
        w = w_in;
        w[b] = w[b] ^ rotl(w[a] + w[d], 7);
        w[c] = w[c] ^ rotl(w[b] + w[a], 9);
        w[d] = w[d] ^ rotl(w[c] + w[b], 13);
        w[a] = w[a] ^ rotl(w[d] + w[c], 18);
        return w;
    endfunction

    // one column round (row low) or one row round (row high)
    function automatic t_state salsa_round(input t_state w_in, input logic row);
        t_state w;
        w = w_in;
        if (!row) begin
            w = quarter(w, 0, 4, 8, 12);
            w = quarter(w, 5, 9, 13, 1);
            w = quarter(w, 10, 14, 2, 6);
            w = quarter(w, 15, 3, 7, 11);
        end else begin
            w = quarter(w, 0, 1, 2, 3);
            w = quarter(w, 5, 6, 7, 4);
            w = quarter(w, 10, 11, 8, 9);
            w = quarter(w, 15, 12, 13, 14);
        end
        return w;
    endfunction

    function automatic t_state init_state(input t_cfg cfg, input logic [63:0] ctr);
        t_state      s;
        logic [63:0] hi_a;
        logic [63:0] hi_b;
        hi_a  = cfg.short_mode ? cfg.key_a : cfg.key_c;
        hi_b  = cfg.short_mode ? cfg.key_b : cfg.key_d;
        s[0]  = cfg.short_mode ? TAU0 : SIG0;
        s[1]  = cfg.key_a[31:0];
        s[2]  = cfg.key_a[63:32];
        s[3]  = cfg.key_b[31:0];
        s[4]  = cfg.key_b[63:32];
        s[5]  = cfg.short_mode ? TAU1 : SIG1;
        s[6]  = cfg.nonce[31:0];
        s[7]  = cfg.nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = cfg.short_mode ? TAU2 : SIG2;
        s[11] = hi_a[31:0];
        s[12] = hi_a[63:32];
        s[13] = hi_b[31:0];
        s[14] = hi_b[63:32];
        s[15] = cfg.short_mode ? TAU3 : SIG3;
        return s;
    endfunction

    function automatic t_state add_state(input t_state a, input t_state b);
        t_state s;
        for (int i = 0; i < 16; i++) begin
            s[i] = a[i] + b[i];
        end
        return s;
    endfunction

endpackage

### rtl/sxor_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// sxor_fifo - small register queue
// First-word fall-through queue used between front and back and on results.
// ============================================================================
module sxor_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

### rtl/sxor_front.sv
`timescale 1ns / 1ps
// ============================================================================
// sxor_front - byte classifier
// Tracks byte position and block counter, marks bytes that open a block.
// ============================================================================
module sxor_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_in,
    input  logic                  i_first_byte,
    input  logic [63:0]           i_start_block,
    input  logic                  i_last_byte,
    output sxor_pkg::t_item       o_item
);

    logic [5:0]  r_pos;
    logic [63:0] r_ctr;
    logic [5:0]  w_pos;
    logic [63:0] w_ctr;
    logic        w_need;

    // first byte restarts at byte 0 of the block named by the item
    assign w_pos  = i_first_byte ? 6'd0 : r_pos;
    assign w_ctr  = i_first_byte ? i_start_block : r_ctr;
    assign w_need = (w_pos == 6'd0);

    assign o_item.data = i_data_in;
    assign o_item.last = i_last_byte;
    assign o_item.need = w_need;
    assign o_item.ctr  = w_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ctr <= '0;
        end else if (i_accept) begin
            r_pos <= w_pos + 6'd1;
            r_ctr <= w_need ? w_ctr + 64'd1 : w_ctr;
        end
    end

endmodule

### rtl/sxor_core.sv
`timescale 1ns / 1ps
// ============================================================================
// sxor_core - keystream block generator
// One Salsa20 round per cycle, then the feed-forward add into a block register.
// ============================================================================
module sxor_core #(
    parameter int ROUND_COUNT = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sxor_pkg::t_cfg                    i_cfg,
    input  sxor_pkg::t_core_ctl               i_ctl,
    output sxor_pkg::t_core_stat              o_stat,
    output logic [sxor_pkg::BLOCK_BITS-1:0]   o_block
);

    // rounds go in column/row pairs
    localparam int NR = ((ROUND_COUNT + 1) / 2) * 2;
    localparam int RW = $clog2(NR + 1);

    logic                 r_busy;
    logic                 r_valid;
    logic [RW-1:0]        r_rnd;
    logic [63:0]          r_tag;
    logic [63:0]          r_ctr;
    sxor_pkg::t_state     r_w;
    sxor_pkg::t_state     r_blk;
    logic                 w_last_step;

    assign w_last_step = r_busy && (r_rnd == RW'(NR));

    assign o_stat.busy  = r_busy;
    assign o_stat.tag   = r_tag;
    assign o_stat.valid = r_valid;
    assign o_stat.ctr   = r_ctr;
    assign o_block      = r_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_rnd   <= '0;
        end else if (i_ctl.flush) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_rnd   <= '0;
        end else begin
            if (i_ctl.take) begin
                r_valid <= 1'b0;
            end
            if (w_last_step) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_tag <= i_ctl.ctr;
            r_w   <= sxor_pkg::init_state(i_cfg, i_ctl.ctr);
        end else if (r_busy && !w_last_step) begin
            r_w <= sxor_pkg::salsa_round(r_w, r_rnd[0]);
        end
        // input words rebuilt from the tag: config cannot change under a run
        if (w_last_step && !i_ctl.start) begin
            r_blk <= sxor_pkg::add_state(r_w, sxor_pkg::init_state(i_cfg, r_tag));
            r_ctr <= r_tag;
        end
    end

    a_busy_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_valid))
        else $error("generator busy and holding a block at once");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last_step && !i_ctl.start && !i_ctl.flush) |=> (r_valid && !r_busy))
        else $error("finished run did not publish its block");

endmodule

### rtl/sxor_back.sv
`timescale 1ns / 1ps
// ============================================================================
// sxor_back - keystream application
// Matches queued bytes against generated blocks, XORs and prefetches ahead.
// ============================================================================
module sxor_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sxor_pkg::t_item                   i_head,
    input  logic                              i_head_valid,
    input  logic                              i_out_full,
    input  logic                              i_flush,
    input  sxor_pkg::t_core_stat              i_stat,
    input  logic [sxor_pkg::BLOCK_BITS-1:0]   i_block,
    output logic                              o_pop,
    output logic                              o_push,
    output sxor_pkg::t_result                 o_result,
    output sxor_pkg::t_core_ctl               o_ctl
);

    logic [sxor_pkg::BLOCK_BITS-1:0] r_cur;
    logic                            w_have;
    logic                            w_in_flight;
    logic                            w_miss;
    logic                            w_fire;
    logic                            w_take;
    logic [7:0]                      w_ks;

    assign w_have      = i_stat.valid && (i_stat.ctr == i_head.ctr);
    assign w_in_flight = i_stat.busy && (i_stat.tag == i_head.ctr);
    assign w_fire      = i_head_valid && !i_out_full && (!i_head.need || w_have);
    assign w_take      = w_fire && i_head.need;
    // head wants a block nobody holds or is making: restart the generator
    assign w_miss      = i_head_valid && i_head.need && !w_have && !w_in_flight;

    assign w_ks = i_head.need ? i_block[7:0] : r_cur[7:0];

    assign o_pop         = w_fire;
    assign o_push        = w_fire;
    assign o_result.data = i_head.data ^ w_ks;
    assign o_result.last = i_head.last;

    // on taking a block, start on the one after it
    assign o_ctl.start = w_take || w_miss;
    assign o_ctl.take  = w_take;
    assign o_ctl.flush = i_flush;
    assign o_ctl.ctr   = w_miss ? i_head.ctr : i_head.ctr + 64'd1;

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_cur <= i_head.need ? {8'h00, i_block[sxor_pkg::BLOCK_BITS-1:8]}
                                 : {8'h00, r_cur[sxor_pkg::BLOCK_BITS-1:8]};
        end
    end

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> !i_stat.valid)
        else $error("taken block still offered");

    a_miss_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_miss && !i_flush) |=> (i_stat.busy && i_stat.tag == $past(i_head.ctr)))
        else $error("missing block not requested");

endmodule

### rtl/salsa20_stream_xor_top.sv
`timescale 1ns / 1ps
// ============================================================================
// salsa20_stream_xor_top - Salsa20 byte stream cipher
// Front classifier, item queue, block generator, XOR back end and result queue.
// ============================================================================
// usage
//   input queue: drive i_data_in, i_first_byte, i_start_block, i_last_byte and
//   raise push; the byte is taken at an edge where full is low. first_byte
//   loads the block counter from i_start_block and restarts at byte 0
//   result queue: o_data_out / o_end_mark are valid while empty is low and
//   leave at an edge where pop is high
//   config: valid/ready write channel, i_cfg_index picks the register
//   (key words a..d, nonce, short key mode); ready is always high. write only
//   while no byte is in flight
// timing
//   a byte inside a block is written into the item queue and then into the
//   result queue before it is on the result ports, one byte per cycle while
//   the result queue has room. one round a cycle, and the next block is
//   fetched while the current one is used. a byte needing a block not held or
//   in progress (counter jump, first byte after reset or a config write)
//   restarts the generator and waits until that block is complete
// reset and stall
//   reset empties both queues, clears the config and the counter to zero and
//   drops any generated block. when pop stays low the result queue fills, the
//   item queue backs up behind it and full rises; nothing is lost
// ============================================================================
module salsa20_stream_xor_top #(
    parameter int ROUND_COUNT = 20,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input queue
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_data_in,
    input  logic                              i_first_byte,
    input  logic [63:0]                       i_start_block,
    input  logic                              i_last_byte,
    // result queue
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_data_out,
    output logic                              o_end_mark,
    // configuration write channel
    input  logic                              valid,
    output logic                              ready,
    input  logic [sxor_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);

    localparam int ITEM_W = $bits(sxor_pkg::t_item);
    localparam int RES_W  = $bits(sxor_pkg::t_result);

    sxor_pkg::t_cfg                  r_cfg;
    logic                            w_cfg_wr;
    logic                            w_accept;
    sxor_pkg::t_item                 w_item;
    sxor_pkg::t_item                 w_head;
    logic [ITEM_W-1:0]               w_head_raw;
    logic                            w_mid_empty;
    logic                            w_back_pop;
    logic                            w_back_push;
    sxor_pkg::t_result               w_result;
    sxor_pkg::t_result               w_out;
    logic [RES_W-1:0]                w_out_raw;
    logic                            w_out_full;
    sxor_pkg::t_core_ctl             w_ctl;
    sxor_pkg::t_core_stat            w_stat;
    logic [sxor_pkg::BLOCK_BITS-1:0] w_block;

    // configuration registers, always ready
    assign ready    = 1'b1;
    assign w_cfg_wr = valid && ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                sxor_pkg::CFG_KEY_A:      r_cfg.key_a      <= i_cfg_data;
                sxor_pkg::CFG_KEY_B:      r_cfg.key_b      <= i_cfg_data;
                sxor_pkg::CFG_KEY_C:      r_cfg.key_c      <= i_cfg_data;
                sxor_pkg::CFG_KEY_D:      r_cfg.key_d      <= i_cfg_data;
                sxor_pkg::CFG_NONCE:      r_cfg.nonce      <= i_cfg_data;
                sxor_pkg::CFG_SHORT_MODE: r_cfg.short_mode <= i_cfg_data[0];
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    // front: classify each accepted byte
    assign w_accept = push && !full;

    sxor_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_in     (i_data_in),
        .i_first_byte  (i_first_byte),
        .i_start_block (i_start_block),
        .i_last_byte   (i_last_byte),
        .o_item        (w_item)
    );

    // queue between front and back, its full flag is the input back-pressure
    sxor_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata (w_item),
        .o_full  (full),
        .i_pop   (w_back_pop),
        .o_rdata (w_head_raw),
        .o_empty (w_mid_empty)
    );

    assign w_head = sxor_pkg::t_item'(w_head_raw);

    // block generator, any config write drops what it holds
    sxor_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat),
        .o_block (w_block)
    );

    sxor_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (!w_mid_empty),
        .i_out_full   (w_out_full),
        .i_flush      (w_cfg_wr),
        .i_stat       (w_stat),
        .i_block      (w_block),
        .o_pop        (w_back_pop),
        .o_push       (w_back_push),
        .o_result     (w_result),
        .o_ctl        (w_ctl)
    );

    // result queue decouples the back from a stalling receiver
    sxor_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_back_push),
        .i_wdata (w_result),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_rdata (w_out_raw),
        .o_empty (empty)
    );

    assign w_out      = sxor_pkg::t_result'(w_out_raw);
    assign o_data_out = w_out.data;
    assign o_end_mark = w_out.last;

endmodule
